// ===== rtl/dspwm_pkg.sv =====
`default_nettype none
package dspwm_pkg;

	localparam int IN_W  = 8;
	localparam int OUT_W = 40;
	localparam int REG_W = 16;
	localparam int STEP_W = 8;

	// button positions in the input word, in handling order
	localparam int BTN_UP_ONE   = 0;
	localparam int BTN_DOWN_ONE = 1;
	localparam int BTN_UP_TWO   = 2;
	localparam int BTN_DOWN_TWO = 3;
	localparam int BTN_CENTER   = 4;
	localparam int BTN_RELAY    = 5;
	localparam int NUM_BTN      = 6;
	localparam int TICK_BIT     = 6;

	localparam logic [REG_W-1:0]  PERIOD_RESET = 16'd1779;
	localparam logic [REG_W-1:0]  CENTER_RESET = 16'd100;
	localparam logic [REG_W-1:0]  UPPER_RESET  = 16'd100;
	localparam logic [REG_W-1:0]  LOWER_RESET  = 16'd0;
	localparam logic [STEP_W-1:0] STEP_RESET   = 8'd1;

	typedef enum logic [2:0] {
		REG_PERIOD = 3'd0,
		REG_CENTER = 3'd1,
		REG_UPPER  = 3'd2,
		REG_LOWER  = 3'd3,
		REG_STEP   = 3'd4
	} cfg_reg_t;

	// press events that act on one duty channel
	typedef struct packed {
		logic up;
		logic down;
		logic center;
	} chan_req_t;

endpackage
`default_nettype wire

// ===== rtl/dual_servo_pwm_with_buttons.sv =====
// Dual servo PWM with six push buttons.
// Input stream (s_axis): one request per sample of the six active-low button
// levels plus a timer-tick flag. Output stream (m_axis): one result per
// request with both motor pins, the relay pin and both current duties.
// Config channel: cfg_index selects period, center, upper, lower or step;
// writes are always taken and are meant for idle periods.
// Pipeline: a request accepted on s_axis passes the input register, then the
// update logic into the output register, from which it is shown on m_axis.
// Throughput: one request per cycle unless m_axis stalls; the button, duty and
// phase update is a single pass of compare/add logic between the two registers.
// A stalled receiver holds the output register; the input register still
// takes one more request, after which s_axis_tready drops until m_axis
// moves again.
// Reset: duties 100, phase 0, latches and relay cleared, registers at
// 1779 / 100 / 100 / 0 / 1, both streams empty.
`default_nettype none
module dual_servo_pwm_with_buttons #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [0] up_one_n, [1] down_one_n, [2] up_two_n, [3] down_two_n,
	// [4] center_n, [5] relay_n, [6] timer_tick, [7] zero
	input  logic [dspwm_pkg::IN_W-1:0]    s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [0] motor_one_pin, [1] motor_two_pin, [2] relay_pin,
	// [18:3] duty_one_now, [34:19] duty_two_now, [39:35] zero
	output logic [dspwm_pkg::OUT_W-1:0]   m_axis_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [dspwm_pkg::REG_W-1:0]   cfg_data
);
	import dspwm_pkg::*;

	localparam int W = COUNT_WIDTH;
	localparam logic [W-1:0] DUTY_INIT = W'(CENTER_RESET);

	logic [REG_W-1:0]  period_q, center_q, upper_q, lower_q;
	logic [STEP_W-1:0] step_q;

	logic               valid_s1;
	logic [NUM_BTN-1:0] btn_s1;
	logic               tick_s1;

	logic [NUM_BTN-1:0] latch_q;
	logic [W-1:0]       duty_one_q, duty_two_q;
	logic               relay_q;
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;

	logic               adv, fire;
	logic [NUM_BTN-1:0] pressed, press_edge;
	chan_req_t          req_one, req_two;
	logic [W-1:0]       duty_one_nxt, duty_two_nxt;
	logic [W-1:0]       period_w, center_w, upper_w, lower_w;
	logic [W-1:0]       phase_nxt, phase_q;
	logic               relay_nxt, pin_one, pin_two;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
			center_q <= CENTER_RESET;
			upper_q  <= UPPER_RESET;
			lower_q  <= LOWER_RESET;
			step_q   <= STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PERIOD: period_q <= cfg_data;
				REG_CENTER: center_q <= cfg_data;
				REG_UPPER:  upper_q  <= cfg_data;
				REG_LOWER:  lower_q  <= cfg_data;
				REG_STEP:   step_q   <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	assign period_w = W'(period_q);
	assign center_w = W'(center_q);
	assign upper_w  = W'(upper_q);
	assign lower_w  = W'(lower_q);

	// handshake: output register frees the input register
	assign adv           = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && adv;
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			btn_s1  <= s_axis_tdata[NUM_BTN-1:0];
			tick_s1 <= s_axis_tdata[TICK_BIT];
		end
	end

	assign pressed    = ~btn_s1;
	assign press_edge = pressed & ~latch_q;

	assign req_one = '{up: press_edge[BTN_UP_ONE], down: press_edge[BTN_DOWN_ONE],
		center: press_edge[BTN_CENTER]};
	assign req_two = '{up: press_edge[BTN_UP_TWO], down: press_edge[BTN_DOWN_TWO],
		center: press_edge[BTN_CENTER]};

	dspwm_duty #(.W(W)) u_duty_one (
		.duty_cur (duty_one_q),
		.req      (req_one),
		.upper    (upper_w),
		.lower    (lower_w),
		.center   (center_w),
		.step     (step_q),
		.duty_nxt (duty_one_nxt)
	);

	dspwm_duty #(.W(W)) u_duty_two (
		.duty_cur (duty_two_q),
		.req      (req_two),
		.upper    (upper_w),
		.lower    (lower_w),
		.center   (center_w),
		.step     (step_q),
		.duty_nxt (duty_two_nxt)
	);

	dspwm_phase #(.W(W)) u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (fire && tick_s1),
		.period    (period_w),
		.phase_nxt (phase_nxt),
		.phase_q   (phase_q)
	);

	assign relay_nxt = relay_q ^ press_edge[BTN_RELAY];
	assign pin_one   = phase_nxt < duty_one_nxt;
	assign pin_two   = phase_nxt < duty_two_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q     <= '0;
			duty_one_q  <= DUTY_INIT;
			duty_two_q  <= DUTY_INIT;
			relay_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= valid_s1;
			end
			if (fire) begin
				latch_q    <= pressed;
				duty_one_q <= duty_one_nxt;
				duty_two_q <= duty_two_nxt;
				relay_q    <= relay_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= {5'b0, 16'(duty_two_nxt), 16'(duty_one_nxt),
				relay_nxt, pin_two, pin_one};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// latches follow the levels of the last processed request
	a_latch_track: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> latch_q == ~$past(btn_s1))
		else $error("press latch does not match last button levels");

	// a tick never leaves the phase beyond the period in force
	a_phase_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && tick_s1) |=> phase_q <= $past(period_w))
		else $error("phase beyond period after tick");

	// every processed request lands in the output register
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("processed request produced no result");

	// a held result keeps the pipeline from overwriting it
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |-> !fire)
		else $error("result overwritten while stalled");

endmodule
`default_nettype wire

// ===== rtl/dspwm_duty.sv =====
`default_nettype none
module dspwm_duty #(
	parameter int W = 16
) (
	input  logic [W-1:0]                  duty_cur,
	input  dspwm_pkg::chan_req_t          req,
	input  logic [W-1:0]                  upper,
	input  logic [W-1:0]                  lower,
	input  logic [W-1:0]                  center,
	input  logic [dspwm_pkg::STEP_W-1:0]  step,
	output logic [W-1:0]                  duty_nxt
);
	import dspwm_pkg::*;

	logic [W:0]   sum;
	logic [W-1:0] after_up;
	logic [W-1:0] gap;
	logic [W-1:0] after_down;

	always_comb begin
		sum = {1'b0, duty_cur} + (W+1)'(step);
		after_up = duty_cur;
		if (req.up && duty_cur < upper) begin
			after_up = (sum > {1'b0, upper}) ? upper : sum[W-1:0];
		end

		// down acts on the value left by up
		gap = after_up - lower;
		after_down = after_up;
		if (req.down && after_up > lower) begin
			after_down = (gap < W'(step)) ? lower : after_up - W'(step);
		end

		duty_nxt = req.center ? center : after_down;
	end

endmodule
`default_nettype wire

// ===== rtl/dspwm_phase.sv =====
`default_nettype none
module dspwm_phase #(
	parameter int W = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         advance,
	input  logic [W-1:0] period,
	output logic [W-1:0] phase_nxt,
	output logic [W-1:0] phase_q
);

	always_comb begin
		phase_nxt = phase_q;
		if (advance) begin
			// wraps also when the period was lowered below the phase
			phase_nxt = (phase_q >= period) ? '0 : phase_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else begin
			phase_q <= phase_nxt;
		end
	end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import dspwm_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 10;
	localparam int NUM_PHASES     = 8;
	localparam int PHASE_ITEMS    = 170;

	// result fields, highest bit first as on m_axis_tdata
	typedef struct packed {
		logic [15:0] duty_two;
		logic [15:0] duty_one;
		logic        relay;
		logic        pin_two;
		logic        pin_one;
	} servo_out_t;

	typedef struct {
		bit          is_cfg;
		cfg_reg_t    idx;
		logic [15:0] val;
		logic [6:0]  buttons;
		bit          typed;
		servo_out_t  want;
	} plan_row_t;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [IN_W-1:0]     s_axis_tdata;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [OUT_W-1:0]    m_axis_tdata;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [2:0]          cfg_index;
	logic [REG_W-1:0]    cfg_data;

	dual_servo_pwm_with_buttons dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor copy of the block
	logic [15:0] period_r, center_r, upper_r, lower_r;
	logic [7:0]  step_r;
	logic [15:0] duty_one_m, duty_two_m, phase_m;
	logic [5:0]  latch_m;
	logic        relay_m;

	servo_out_t  pending_outs[$];
	plan_row_t   plan[$];
	logic [5:0]  held_levels;
	int          idle_pct;
	int          stall_pct;
	int          hold_left;
	int          mismatches;
	int          quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit press_edge(int idx, logic level_n);
		if (!level_n && !latch_m[idx]) begin
			latch_m[idx] = 1'b1;
			return 1'b1;
		end
		if (level_n)
			latch_m[idx] = 1'b0;
		return 1'b0;
	endfunction

	function automatic logic [15:0] duty_raise(logic [15:0] d);
		logic [16:0] n;
		if (d >= upper_r)
			return d;
		n = {1'b0, d} + {9'd0, step_r};
		return (n > {1'b0, upper_r}) ? upper_r : n[15:0];
	endfunction

	function automatic logic [15:0] duty_lower(logic [15:0] d);
		if (d <= lower_r)
			return d;
		return ((d - lower_r) < {8'd0, step_r}) ? lower_r : d - {8'd0, step_r};
	endfunction

	function automatic servo_out_t servo_step(logic [6:0] b);
		servo_out_t r;
		if (press_edge(BTN_UP_ONE, b[BTN_UP_ONE]))
			duty_one_m = duty_raise(duty_one_m);
		if (press_edge(BTN_DOWN_ONE, b[BTN_DOWN_ONE]))
			duty_one_m = duty_lower(duty_one_m);
		if (press_edge(BTN_UP_TWO, b[BTN_UP_TWO]))
			duty_two_m = duty_raise(duty_two_m);
		if (press_edge(BTN_DOWN_TWO, b[BTN_DOWN_TWO]))
			duty_two_m = duty_lower(duty_two_m);
		if (press_edge(BTN_CENTER, b[BTN_CENTER])) begin
			duty_one_m = center_r;
			duty_two_m = center_r;
		end
		if (press_edge(BTN_RELAY, b[BTN_RELAY]))
			relay_m = ~relay_m;
		if (b[TICK_BIT])
			phase_m = (phase_m >= period_r) ? 16'd0 : phase_m + 16'd1;
		r.pin_one  = phase_m < duty_one_m;
		r.pin_two  = phase_m < duty_two_m;
		r.relay    = relay_m;
		r.duty_one = duty_one_m;
		r.duty_two = duty_two_m;
		return r;
	endfunction

	// buttons mostly held for a while, with occasional raw noise
	function automatic logic [6:0] next_buttons();
		logic [6:0] v;
		if ($urandom_range(0, 9) == 0) begin
			v = 7'($urandom);
		end else begin
			for (int i = 0; i < NUM_BTN; i++)
				if ($urandom_range(0, 3) == 0)
					held_levels[i] = ~held_levels[i];
			v = {1'($urandom_range(0, 1)), held_levels};
		end
		return v;
	endfunction

	function automatic servo_out_t outs(bit p1, bit p2, bit rl, int d1, int d2);
		servo_out_t r;
		r.pin_one  = p1;
		r.pin_two  = p2;
		r.relay    = rl;
		r.duty_one = d1[15:0];
		r.duty_two = d2[15:0];
		return r;
	endfunction

	function automatic void add_item(logic [6:0] b);
		plan_row_t r;
		r = '{idx: REG_PERIOD, default: '0};
		r.buttons = b;
		plan.push_back(r);
	endfunction

	function automatic void add_checked(logic [6:0] b, servo_out_t w);
		plan_row_t r;
		r = '{idx: REG_PERIOD, default: '0};
		r.buttons = b;
		r.typed = 1'b1;
		r.want = w;
		plan.push_back(r);
	endfunction

	function automatic void add_cfg(cfg_reg_t idx, logic [15:0] val);
		plan_row_t r;
		r = '{idx: REG_PERIOD, default: '0};
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.val = val;
		plan.push_back(r);
	endfunction

	// called right after a falling edge; leaves tvalid high for the caller
	task automatic send(logic [6:0] b, bit typed, servo_out_t want);
		servo_out_t got_pred;
		while ($urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, b};
		do @(posedge clk); while (!s_axis_tready);
		got_pred = servo_step(b);
		pending_outs.push_back(typed ? want : got_pred);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_outs.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PERIOD: period_r = val;
			REG_CENTER: center_r = val;
			REG_UPPER:  upper_r  = val;
			REG_LOWER:  lower_r  = val;
			REG_STEP:   step_r   = val[7:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_config(logic [15:0] p, logic [15:0] c, logic [15:0] u,
			logic [15:0] l, logic [7:0] s);
		wait_idle();
		write_reg(REG_PERIOD, p);
		write_reg(REG_CENTER, c);
		write_reg(REG_UPPER, u);
		write_reg(REG_LOWER, l);
		write_reg(REG_STEP, {8'd0, s});
		cfg_valid <= 1'b0;
	endtask

	// receiver: random stalls, plus a long hold-off when asked
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		servo_out_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[$bits(servo_out_t)-1:0];
			if (pending_outs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h with no request pending", got);
			end else begin
				want = pending_outs.pop_front();
				if (got.pin_one != want.pin_one || got.pin_two != want.pin_two ||
						got.relay != want.relay || got.duty_one != want.duty_one ||
						got.duty_two != want.duty_two) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result mismatch: pin1 %b/%b pin2 %b/%b relay %b/%b ",
							"duty1 %0d/%0d duty2 %0d/%0d (got/expected)"},
							got.pin_one, want.pin_one, got.pin_two, want.pin_two,
							got.relay, want.relay, got.duty_one, want.duty_one,
							got.duty_two, want.duty_two);
				end
			end
		end
	end

	// nothing moving on any channel for too long ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		logic [15:0] ph_period[NUM_PHASES];
		logic [15:0] ph_center[NUM_PHASES];
		logic [15:0] ph_upper[NUM_PHASES];
		logic [15:0] ph_lower[NUM_PHASES];
		logic [7:0]  ph_step[NUM_PHASES];
		int ph_idle[NUM_PHASES];
		int ph_stall[NUM_PHASES];
		servo_out_t none_want;

		ph_period = '{16'd7, 16'd1, 16'd20, 16'd65535, 16'd0, 16'd12, 16'd0, 16'd1779};
		ph_center = '{16'd3, 16'd0, 16'd10, 16'd65535, 16'd5, 16'd40, 16'd0, 16'd100};
		ph_upper  = '{16'd6, 16'd2, 16'd65535, 16'd65535, 16'd10, 16'd30, 16'd0, 16'd100};
		ph_lower  = '{16'd1, 16'd0, 16'd0, 16'd65535, 16'd3, 16'd8, 16'd0, 16'd0};
		ph_step   = '{8'd1, 8'd1, 8'd255, 8'd255, 8'd0, 8'd7, 8'd0, 8'd1};
		ph_idle   = '{0, 66, 0, 13, 0, 0, 66, 13};
		ph_stall  = '{0, 0, 66, 13, 0, 66, 0, 13};

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_PERIOD;
		cfg_data = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		mismatches = 0;
		quiet_cycles = 0;
		held_levels = 6'h3F;
		none_want = '0;

		period_r = PERIOD_RESET;
		center_r = CENTER_RESET;
		upper_r = UPPER_RESET;
		lower_r = LOWER_RESET;
		step_r = STEP_RESET;
		duty_one_m = 16'd100;
		duty_two_m = 16'd100;
		phase_m = '0;
		latch_m = '0;
		relay_m = 1'b0;

		// reset values: held button acts once, relay toggles per press
		add_checked(7'h3F, outs(1, 1, 0, 100, 100));
		add_checked(7'h3E, outs(1, 1, 0, 100, 100));
		add_checked(7'h3C, outs(1, 1, 0, 99, 100));
		add_checked(7'h3C, outs(1, 1, 0, 99, 100));
		add_checked(7'h1F, outs(1, 1, 1, 99, 100));
		add_checked(7'h3F, outs(1, 1, 1, 99, 100));
		add_checked(7'h1F, outs(1, 1, 0, 99, 100));
		add_checked(7'h7F, outs(1, 1, 0, 99, 100));
		// short period, center to zero duty, biggest step
		add_cfg(REG_PERIOD, 16'd2);
		add_cfg(REG_CENTER, 16'd0);
		add_cfg(REG_UPPER, 16'd65535);
		add_cfg(REG_LOWER, 16'd0);
		add_cfg(REG_STEP, 16'd255);
		add_item(7'h6F);
		add_item(7'h7A);
		add_item(7'h7F);
		add_item(7'h35);
		// saturation at both limits
		add_cfg(REG_UPPER, 16'd300);
		add_cfg(REG_LOWER, 16'd250);
		add_cfg(REG_STEP, 16'd200);
		add_item(7'h2F);
		add_item(7'h3A);
		add_item(7'h3F);
		add_item(7'h3A);
		add_item(7'h35);
		add_item(7'h3F);
		add_item(7'h35);
		// zero step, zero period
		add_cfg(REG_STEP, 16'd0);
		add_cfg(REG_PERIOD, 16'd0);
		add_item(7'h7F);
		add_item(7'h7A);
		// widest values; then every button at once
		add_cfg(REG_PERIOD, 16'd65535);
		add_cfg(REG_CENTER, 16'd65535);
		add_cfg(REG_UPPER, 16'd65535);
		add_cfg(REG_STEP, 16'd1);
		add_item(7'h6F);
		add_item(7'h7A);
		add_item(7'h00);
		add_item(7'h7F);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		for (int i = 0; i < plan.size(); i++) begin
			if (plan[i].is_cfg) begin
				if (i == 0 || !plan[i-1].is_cfg)
					wait_idle();
				write_reg(plan[i].idx, plan[i].val);
				if (i == plan.size() - 1 || !plan[i+1].is_cfg)
					cfg_valid <= 1'b0;
			end else begin
				send(plan[i].buttons, plan[i].typed, plan[i].want);
			end
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph == 6)
				set_config(16'($urandom_range(1, 64)), 16'($urandom_range(0, 80)),
					16'($urandom_range(0, 80)), 16'($urandom_range(0, 40)),
					8'($urandom_range(1, 255)));
			else
				set_config(ph_period[ph], ph_center[ph], ph_upper[ph], ph_lower[ph],
					ph_step[ph]);
			idle_pct = ph_idle[ph];
			stall_pct = ph_stall[ph];
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// long receiver hold-off with the sender still pushing
				if (k == 80 && ph == 0)
					hold_left = 250;
				if (k == 80 && ph == 4)
					wait_idle();
				send(next_buttons(), 1'b0, none_want);
			end
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending_outs.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
